[hw/rtl/sts_pkg.sv]
package sts_pkg;

    localparam int LineWidthDef = 16;
    localparam int ColumnWidthDef = 16;
    localparam int LengthWidthDef = 16;
    localparam int MaxRecords = 3;
    localparam int WordBytes = 7;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_IDENT   = 3'd1,
        M_NUMBER  = 3'd2,
        M_STRING  = 3'd3,
        M_ESCAPE  = 3'd4,
        M_LESS    = 3'd5,
        M_GREATER = 3'd6,
        M_BANG    = 3'd7
    } t_mode;

    localparam logic [5:0] K_END = 6'd0;
    localparam logic [5:0] K_INT = 6'd1;
    localparam logic [5:0] K_DEC = 6'd2;
    localparam logic [5:0] K_STR = 6'd3;
    localparam logic [5:0] K_BOOL = 6'd4;
    localparam logic [5:0] K_IDENT = 6'd5;
    localparam logic [5:0] K_PLUS = 6'd28;
    localparam logic [5:0] K_MINUS = 6'd29;
    localparam logic [5:0] K_STAR = 6'd30;
    localparam logic [5:0] K_SLASH = 6'd31;
    localparam logic [5:0] K_EQ = 6'd32;
    localparam logic [5:0] K_NE = 6'd33;
    localparam logic [5:0] K_LT = 6'd34;
    localparam logic [5:0] K_LE = 6'd35;
    localparam logic [5:0] K_GT = 6'd36;
    localparam logic [5:0] K_GE = 6'd37;
    localparam logic [5:0] K_LPAR = 6'd38;
    localparam logic [5:0] K_RPAR = 6'd39;
    localparam logic [5:0] K_COMMA = 6'd40;
    localparam logic [5:0] K_SEMI = 6'd41;
    localparam logic [5:0] K_DOT = 6'd42;
    localparam logic [5:0] K_UNKNOWN = 6'd43;
    localparam logic [5:0] K_UNTERM = 6'd44;

    localparam logic [7:0] C_DOT = 8'h2E;
    localparam logic [7:0] C_UNDER = 8'h5F;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_EQUAL = 8'h3D;
    localparam logic [7:0] C_NL = 8'h0A;

    function automatic logic letter_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    // Words are right-aligned in the buffer, so a length check plus a compare
    // of the packed value identifies them.
    function automatic logic [5:0] word_kind(input logic [55:0] w, input logic [2:0] n);
        logic [5:0] k;
        k = K_IDENT;
        case ({n, w})
            {3'd6, 56'h00435245415445}: k = 6'd6;
            {3'd4, 56'h00000044524F50}: k = 6'd7;
            {3'd5, 56'h00005441424C45}: k = 6'd8;
            {3'd6, 56'h00494E53455254}: k = 6'd9;
            {3'd4, 56'h000000494E544F}: k = 6'd10;
            {3'd6, 56'h0056414C554553}: k = 6'd11;
            {3'd6, 56'h0053454C454354}: k = 6'd12;
            {3'd4, 56'h00000046524F4D}: k = 6'd13;
            {3'd5, 56'h00005748455245}: k = 6'd14;
            {3'd6, 56'h0044454C455445}: k = 6'd15;
            {3'd2, 56'h00000000004946}: k = 6'd16;
            {3'd3, 56'h000000004E4F54}: k = 6'd17;
            {3'd6, 56'h00455849535453}: k = 6'd18;
            {3'd3, 56'h00000000414E44}: k = 6'd19;
            {3'd2, 56'h000000000F4F52 & 56'h0000000000FFFF}: k = 6'd20;
            {3'd3, 56'h00000000494E54}: k = 6'd21;
            {3'd6, 56'h00535452494E47}: k = 6'd22;
            {3'd4, 56'h000000424F4F4C}: k = 6'd23;
            {3'd7, 56'h444543494D414C}: k = 6'd24;
            {3'd3, 56'h0000000053494E}: k = 6'd25;
            {3'd3, 56'h00000000434F53}: k = 6'd26;
            {3'd6, 56'h00535542535452}: k = 6'd27;
            {3'd4, 56'h00000054525545}: k = K_BOOL;
            {3'd5, 56'h000046414C5345}: k = K_BOOL;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h2B: k = K_PLUS;
            8'h2D: k = K_MINUS;
            8'h2A: k = K_STAR;
            8'h2F: k = K_SLASH;
            8'h3D: k = K_EQ;
            8'h28: k = K_LPAR;
            8'h29: k = K_RPAR;
            8'h2C: k = K_COMMA;
            8'h3B: k = K_SEMI;
            8'h2E: k = K_DOT;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

[hw/rtl/sql_token_scanner.sv]
// SQL token scanner.
// The input channel carries one text byte per item, or an end marker when
// i_end_of_input is high. Each item causes up to three records on the output
// channel: value-byte records (o_record_kind low) with the token text, and
// token-end records (o_record_kind high) with kind, start position and length.
// o_last marks the final record of an item; an item may cause no record.
// The scanner state is updated in the cycle an item is accepted, and its
// records are placed in a three-entry result register, so the first record
// appears in the cycle after acceptance. Unless the receiver stalls, records
// leave one per cycle, and the next item is taken while the final record of
// the previous one is being delivered, so items that each cause at most one
// record run at one item per cycle; an item with more records stalls input
// until only its final record is left. When the receiver stalls, the
// current record holds, and input is stalled while any record of the
// previous item is still waiting. Reset sets the position to line 1,
// column 1 and clears all records; an end marker resets the scanner state.
module sql_token_scanner
    import sts_pkg::*;
#(
    parameter int LINE_WIDTH = LineWidthDef,
    parameter int COLUMN_WIDTH = ColumnWidthDef,
    parameter int LENGTH_WIDTH = LengthWidthDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_char_byte,
    input  logic                    i_end_of_input,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_record_kind,
    output logic [7:0]              o_value_byte,
    output logic [5:0]              o_token_kind,
    output logic [LINE_WIDTH-1:0]   o_start_line,
    output logic [COLUMN_WIDTH-1:0] o_start_column,
    output logic [LENGTH_WIDTH-1:0] o_value_length,
    output logic                    o_last
);

    typedef struct packed {
        logic                    kind;
        logic [7:0]              byte_val;
        logic [5:0]              tk;
        logic [LINE_WIDTH-1:0]   ln;
        logic [COLUMN_WIDTH-1:0] col;
        logic [LENGTH_WIDTH-1:0] len;
        logic                    last;
    } t_rec;

    localparam logic [LINE_WIDTH-1:0] LineMax = '1;
    localparam logic [COLUMN_WIDTH-1:0] ColMax = '1;
    localparam logic [LENGTH_WIDTH-1:0] LenMax = '1;

    t_mode r_mode, n_mode;
    logic [LINE_WIDTH-1:0] r_line, n_line, r_tline, n_tline;
    logic [COLUMN_WIDTH-1:0] r_col, n_col, r_tcol, n_tcol;
    logic [LENGTH_WIDTH-1:0] r_tlen, n_tlen;
    logic r_dec, n_dec, r_dq, n_dq;
    logic [55:0] r_word, n_word;

    t_rec r_q [MaxRecords];
    t_rec n_q [MaxRecords];
    logic [1:0] r_cnt, n_cnt;
    t_rec recs [MaxRecords];
    logic [1:0] rc;

    logic accept, pop;

    assign pop = (r_cnt != 2'd0) && !i_stall;
    assign o_stall = (r_cnt > 2'd1) || (r_cnt == 2'd1 && i_stall);
    assign accept = i_valid && !o_stall;

    always_comb begin
        logic [7:0] c;
        logic fresh;
        logic [5:0] sk;
        logic [LENGTH_WIDTH-1:0] tl;
        c = i_char_byte;
        fresh = 1'b0;
        n_mode = r_mode;
        n_line = r_line;
        n_col = r_col;
        n_tline = r_tline;
        n_tcol = r_tcol;
        n_tlen = r_tlen;
        n_dec = r_dec;
        n_dq = r_dq;
        n_word = r_word;
        rc = 2'd0;
        sk = single_kind(c);
        for (int i = 0; i < MaxRecords; i++) begin
            recs[i] = '0;
        end
        tl = r_tlen;

        if (i_end_of_input) begin
            case (r_mode)
                M_IDENT, M_NUMBER, M_LESS, M_GREATER, M_BANG, M_STRING, M_ESCAPE: begin
                    recs[0].kind = 1'b1;
                    recs[0].ln = r_tline;
                    recs[0].col = r_tcol;
                    recs[0].len = r_tlen;
                    case (r_mode)
                        M_IDENT: recs[0].tk = (r_tlen > LENGTH_WIDTH'(7)) ? K_IDENT :
                            word_kind(r_word, r_tlen[2:0]);
                        M_NUMBER: recs[0].tk = r_dec ? K_DEC : K_INT;
                        M_LESS: recs[0].tk = K_LT;
                        M_GREATER: recs[0].tk = K_GT;
                        M_BANG: recs[0].tk = K_UNKNOWN;
                        default: recs[0].tk = K_UNTERM;
                    endcase
                    rc = 2'd1;
                end
                default: rc = 2'd0;
            endcase
            recs[rc].kind = 1'b1;
            recs[rc].tk = K_END;
            recs[rc].ln = r_line;
            recs[rc].col = r_col;
            recs[rc].last = 1'b1;
            rc = rc + 2'd1;
            n_mode = M_IDLE;
            n_line = LINE_WIDTH'(1);
            n_col = COLUMN_WIDTH'(1);
            n_tline = LINE_WIDTH'(1);
            n_tcol = COLUMN_WIDTH'(1);
            n_tlen = '0;
            n_dec = 1'b0;
            n_dq = 1'b0;
            n_word = '0;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (letter_byte(c) || digit_byte(c) || c == C_UNDER) begin
                        if (r_tlen < LENGTH_WIDTH'(7)) n_word = {r_word[47:0], to_upper(c)};
                        recs[0].byte_val = to_upper(c);
                        rc = 2'd1;
                        if (r_tlen != LenMax) n_tlen = r_tlen + 1'b1;
                    end else begin
                        recs[0].kind = 1'b1;
                        recs[0].tk = (r_tlen > LENGTH_WIDTH'(7)) ? K_IDENT :
                            word_kind(r_word, r_tlen[2:0]);
                        recs[0].ln = r_tline;
                        recs[0].col = r_tcol;
                        recs[0].len = r_tlen;
                        rc = 2'd1;
                        fresh = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (digit_byte(c) || (c == C_DOT && !r_dec)) begin
                        if (c == C_DOT) n_dec = 1'b1;
                        recs[0].byte_val = c;
                        rc = 2'd1;
                        if (r_tlen != LenMax) n_tlen = r_tlen + 1'b1;
                    end else begin
                        recs[0].kind = 1'b1;
                        recs[0].tk = r_dec ? K_DEC : K_INT;
                        recs[0].ln = r_tline;
                        recs[0].col = r_tcol;
                        recs[0].len = r_tlen;
                        rc = 2'd1;
                        fresh = 1'b1;
                    end
                end
                M_STRING: begin
                    if (c == (r_dq ? C_DQUOTE : C_SQUOTE)) begin
                        recs[0].kind = 1'b1;
                        recs[0].tk = K_STR;
                        recs[0].ln = r_tline;
                        recs[0].col = r_tcol;
                        recs[0].len = r_tlen;
                        rc = 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == C_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end else begin
                        recs[0].byte_val = c;
                        rc = 2'd1;
                        if (r_tlen != LenMax) n_tlen = r_tlen + 1'b1;
                    end
                end
                M_ESCAPE: begin
                    case (c)
                        8'h6E: recs[0].byte_val = 8'h0A;
                        8'h74: recs[0].byte_val = 8'h09;
                        8'h72: recs[0].byte_val = 8'h0D;
                        default: recs[0].byte_val = c;
                    endcase
                    rc = 2'd1;
                    if (r_tlen != LenMax) n_tlen = r_tlen + 1'b1;
                    n_mode = M_STRING;
                end
                M_LESS, M_GREATER, M_BANG: begin
                    recs[0].kind = 1'b0;
                    if (c == C_EQUAL) begin
                        recs[0].byte_val = c;
                        tl = (r_tlen != LenMax) ? r_tlen + 1'b1 : r_tlen;
                        n_tlen = tl;
                        recs[1].kind = 1'b1;
                        recs[1].tk = (r_mode == M_LESS) ? K_LE :
                            ((r_mode == M_GREATER) ? K_GE : K_NE);
                        recs[1].ln = r_tline;
                        recs[1].col = r_tcol;
                        recs[1].len = tl;
                        rc = 2'd2;
                        n_mode = M_IDLE;
                    end else begin
                        recs[0].kind = 1'b1;
                        recs[0].tk = (r_mode == M_LESS) ? K_LT :
                            ((r_mode == M_GREATER) ? K_GT : K_UNKNOWN);
                        recs[0].ln = r_tline;
                        recs[0].col = r_tcol;
                        recs[0].len = r_tlen;
                        rc = 2'd1;
                        fresh = 1'b1;
                    end
                end
                default: fresh = 1'b1;
            endcase

            if (fresh) begin
                n_mode = M_IDLE;
                if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) begin
                    n_mode = M_IDLE;
                end else begin
                    n_tline = r_line;
                    n_tcol = r_col;
                    n_dec = 1'b0;
                    n_word = '0;
                    if (c == C_SQUOTE || c == C_DQUOTE) begin
                        n_mode = M_STRING;
                        n_dq = (c == C_DQUOTE);
                        n_tlen = '0;
                    end else begin
                        n_tlen = LENGTH_WIDTH'(1);
                        recs[rc].byte_val = c;
                        if (digit_byte(c)) begin
                            n_mode = M_NUMBER;
                        end else if (letter_byte(c) || c == C_UNDER) begin
                            n_mode = M_IDENT;
                            n_word = {48'd0, to_upper(c)};
                            recs[rc].byte_val = to_upper(c);
                        end else if (c == 8'h3C) begin
                            n_mode = M_LESS;
                        end else if (c == 8'h3E) begin
                            n_mode = M_GREATER;
                        end else if (c == 8'h21) begin
                            n_mode = M_BANG;
                        end else begin
                            recs[rc + 2'd1].kind = 1'b1;
                            recs[rc + 2'd1].tk = sk;
                            recs[rc + 2'd1].ln = r_line;
                            recs[rc + 2'd1].col = r_col;
                            recs[rc + 2'd1].len = LENGTH_WIDTH'(1);
                            rc = rc + 2'd1;
                        end
                        rc = rc + 2'd1;
                    end
                end
            end

            if (c == C_NL) begin
                if (r_line != LineMax) n_line = r_line + 1'b1;
                n_col = COLUMN_WIDTH'(1);
            end else if (r_col != ColMax) begin
                n_col = r_col + 1'b1;
            end
            if (rc != 2'd0) recs[rc - 2'd1].last = 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < MaxRecords; i++) begin
            n_q[i] = r_q[i];
        end
        n_cnt = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_cnt = r_cnt - 2'd1;
        end
        if (accept) begin
            for (int i = 0; i < MaxRecords; i++) begin
                n_q[i] = recs[i];
            end
            n_cnt = rc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_line <= LINE_WIDTH'(1);
            r_col <= COLUMN_WIDTH'(1);
            r_tline <= LINE_WIDTH'(1);
            r_tcol <= COLUMN_WIDTH'(1);
            r_tlen <= '0;
            r_dec <= 1'b0;
            r_dq <= 1'b0;
            r_word <= '0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_mode <= n_mode;
                r_line <= n_line;
                r_col <= n_col;
                r_tline <= n_tline;
                r_tcol <= n_tcol;
                r_tlen <= n_tlen;
                r_dec <= n_dec;
                r_dq <= n_dq;
                r_word <= n_word;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MaxRecords; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_record_kind = r_q[0].kind;
    assign o_value_byte = r_q[0].byte_val;
    assign o_token_kind = r_q[0].tk;
    assign o_start_line = r_q[0].ln;
    assign o_start_column = r_q[0].col;
    assign o_value_length = r_q[0].len;
    assign o_last = r_q[0].last;

endmodule
